// ===== rtl/cwrp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper function of the cache way replacement policy unit.
package cwrp_pkg;

  localparam int unsigned CMD_W      = 1;
  localparam int unsigned SET_IDX_W  = 6;
  localparam int unsigned HIT_WAY_W  = 3;
  localparam int unsigned CLEAN_W    = 8;
  localparam int unsigned VICTIM_W   = 3;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned WAYS_CFG_W = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned LFSR_W     = 16;
  localparam int unsigned OP_W       = 2;

  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  localparam logic [MODE_W-1:0] MODE_LRU   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RAND  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS   = 1'b1;

  localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 4'd8;
  localparam logic [LFSR_W-1:0]     LFSR_SEED  = 16'hACE1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_STAMP = 2'd1,
    OP_LRU   = 2'd2,
    OP_RAND  = 2'd3
  } cwrp_op_e;

  typedef struct packed {
    logic [MODE_W-1:0]     policy_mode;
    logic [WAYS_CFG_W-1:0] ways_in_use;
  } cwrp_cfg_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] r);
    logic fb;
    fb = r[0] ^ r[2] ^ r[3] ^ r[5];
    return {fb, r[LFSR_W-1:1]};
  endfunction

endpackage

// ===== rtl/cwrp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module cwrp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cwrp_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, decodes them into queue entries and runs the random generator.
module cwrp_front import cwrp_pkg::*; #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned MAX_WAYS = 8,
  localparam int unsigned DEPTH   = NUM_SETS * MAX_WAYS,
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int unsigned ENTRY_W = OP_W + ADDR_W + MAX_WAYS + WAY_W + VICTIM_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cwrp_cfg_t            cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [SET_IDX_W-1:0] set_index_i,
  input  logic [HIT_WAY_W-1:0] hit_way_i,
  input  logic [CLEAN_W-1:0]   clean_mask_i,
  input  logic                 q_full_i,
  input  logic                 clearing_i,
  output logic                 push_o,
  output logic [ENTRY_W-1:0]   entry_o
);

  localparam int unsigned SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned SET_VALS = 2 ** SET_IDX_W;
  localparam int unsigned CNT_W    = $clog2(MAX_WAYS + 1);
  localparam int unsigned PROD_W   = LFSR_W + CNT_W;

  typedef struct packed {
    cwrp_op_e            op;
    logic [ADDR_W-1:0]   addr;
    logic [MAX_WAYS-1:0] allow;
    logic [WAY_W-1:0]    last;
    logic [VICTIM_W-1:0] rnd;
  } q_entry_t;

  logic [SET_W-1:0]    set_tbl [SET_VALS];
  logic [SET_W-1:0]    set_mod;
  logic [CNT_W-1:0]    ways;
  logic [MAX_WAYS-1:0] all_mask;
  logic [MAX_WAYS-1:0] clean_ext;
  logic [MAX_WAYS-1:0] clean_allow;
  logic [31:0]         clean_w;
  logic [31:0]         rnd_w;
  logic [ADDR_W-1:0]   base;
  logic [PROD_W-1:0]   rnd_prod;
  logic [LFSR_W-1:0]   lfsr_q;
  logic [LFSR_W-1:0]   lfsr_d;
  logic [LFSR_W-1:0]   lfsr_nxt;
  logic                accept;
  q_entry_t            entry;

  for (genvar g = 0; g < SET_VALS; g++) begin : g_set_tbl
    localparam int unsigned SetMod = g % NUM_SETS;
    assign set_tbl[g] = SET_W'(SetMod);
  end

  assign set_mod    = set_tbl[set_index_i];
  assign in_stall_o = q_full_i | clearing_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = accept;
  assign lfsr_nxt   = lfsr_step(lfsr_q);

  always_comb begin
    priority if (cfg_i.ways_in_use == '0) begin
      ways = CNT_W'(1);
    end else if (32'(cfg_i.ways_in_use) > MAX_WAYS) begin
      ways = CNT_W'(MAX_WAYS);
    end else begin
      ways = CNT_W'(cfg_i.ways_in_use);
    end

    for (int i = 0; i < MAX_WAYS; i++) begin
      all_mask[i] = 32'(i) < 32'(ways);
    end

    clean_w     = 32'(clean_mask_i);
    clean_ext   = clean_w[MAX_WAYS-1:0];
    clean_allow = clean_ext & all_mask;

    rnd_prod = PROD_W'(lfsr_nxt) * PROD_W'(ways);
    rnd_w    = 32'(rnd_prod[LFSR_W +: CNT_W]);

    base = ADDR_W'(set_mod) * ADDR_W'(MAX_WAYS);

    entry.rnd  = rnd_w[VICTIM_W-1:0];
    entry.last = WAY_W'(ways - CNT_W'(1));
    if (cfg_i.policy_mode == MODE_CLEAN && clean_allow != '0) begin
      entry.allow = clean_allow;
    end else begin
      entry.allow = all_mask;
    end

    if (command_i == CMD_QUERY) begin
      entry.op   = (cfg_i.policy_mode == MODE_RAND) ? OP_RAND : OP_LRU;
      entry.addr = base;
    end else begin
      if (cfg_i.policy_mode != MODE_RAND && 32'(hit_way_i) < MAX_WAYS) begin
        entry.op = OP_STAMP;
      end else begin
        entry.op = OP_TICK;
      end
      entry.addr = base + ADDR_W'(hit_way_i);
    end

    lfsr_d = lfsr_q;
    if (accept && command_i == CMD_QUERY && cfg_i.policy_mode == MODE_RAND) begin
      lfsr_d = lfsr_nxt;
    end
  end

  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LFSR_SEED;
    end else begin
      lfsr_q <= lfsr_d;
    end
  end

endmodule

// ===== rtl/cwrp_queue.sv =====
`timescale 1ns / 1ps
// Two-entry request queue between the front end and the back end.
module cwrp_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] entry_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] entry_o,
  input  logic             pop_i
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = 1;
  localparam int unsigned CNT_W = 2;

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/cwrp_back.sv =====
`timescale 1ns / 1ps
// Back end: stamp RAM, access clock, clearing pass, oldest-way scan and result register.
module cwrp_back import cwrp_pkg::*; #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned MAX_WAYS = 8,
  localparam int unsigned DEPTH   = NUM_SETS * MAX_WAYS,
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int unsigned ENTRY_W = OP_W + ADDR_W + MAX_WAYS + WAY_W + VICTIM_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  logic [ENTRY_W-1:0]  q_entry_i,
  output logic                q_pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VICTIM_W-1:0] victim_way_o
);

  typedef struct packed {
    cwrp_op_e            op;
    logic [ADDR_W-1:0]   addr;
    logic [MAX_WAYS-1:0] allow;
    logic [WAY_W-1:0]    last;
    logic [VICTIM_W-1:0] rnd;
  } q_entry_t;

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  q_entry_t            head;
  logic [1:0]          state_q, state_d;
  logic [ADDR_W-1:0]   clr_addr_q, clr_addr_d;
  logic [STAMP_W-1:0]  clock_q, clock_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [MAX_WAYS-1:0] allow_q, allow_d;
  logic [WAY_W-1:0]    last_q, last_d;
  logic [WAY_W-1:0]    idx_q, idx_d;
  logic                have_q, have_d;
  logic [WAY_W-1:0]    best_q, best_d;
  logic [STAMP_W-1:0]  best_stamp_q, best_stamp_d;
  logic                out_valid_q, out_valid_d;
  logic [VICTIM_W-1:0] victim_q, victim_d;
  logic                out_free;
  logic                out_load;
  logic                cand_better;
  logic [31:0]         best_w;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [STAMP_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [STAMP_W-1:0]  ram_rdata;

  assign head        = q_entry_i;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign cand_better = allow_q[idx_q] & (~have_q | (ram_rdata < best_stamp_q));
  assign best_w      = 32'(best_q);
  assign clearing_o  = state_q == S_CLEAR;

  cwrp_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    clock_d      = clock_q;
    base_d       = base_q;
    allow_d      = allow_q;
    last_d       = last_q;
    idx_d        = idx_q;
    have_d       = have_q;
    best_d       = best_q;
    best_stamp_d = best_stamp_q;
    victim_d     = victim_q;
    q_pop_o      = 1'b0;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = clr_addr_q;
    ram_wdata    = '0;
    ram_raddr    = head.addr;

    unique case (state_q)
      S_CLEAR: begin
        ram_we     = 1'b1;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          unique case (head.op)
            OP_TICK: begin
              q_pop_o = 1'b1;
              clock_d = clock_q + STAMP_W'(1);
            end
            OP_STAMP: begin
              q_pop_o   = 1'b1;
              ram_we    = 1'b1;
              ram_waddr = head.addr;
              ram_wdata = clock_q;
              clock_d   = clock_q + STAMP_W'(1);
            end
            OP_RAND: begin
              if (out_free) begin
                q_pop_o  = 1'b1;
                out_load = 1'b1;
                victim_d = head.rnd;
              end
            end
            OP_LRU: begin
              q_pop_o = 1'b1;
              base_d  = head.addr;
              allow_d = head.allow;
              last_d  = head.last;
              idx_d   = '0;
              have_d  = 1'b0;
              best_d  = '0;
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_raddr = base_q + ADDR_W'(idx_q) + ADDR_W'(1);
        if (cand_better) begin
          have_d       = 1'b1;
          best_d       = idx_q;
          best_stamp_d = ram_rdata;
        end
        idx_d = idx_q + WAY_W'(1);
        if (idx_q == last_q) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
          victim_d = best_w[VICTIM_W-1:0];
          state_d  = S_IDLE;
        end
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      clock_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      clock_q     <= clock_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    allow_q      <= allow_d;
    last_q       <= last_d;
    idx_q        <= idx_d;
    have_q       <= have_d;
    best_q       <= best_d;
    best_stamp_q <= best_stamp_d;
    victim_q     <= victim_d;
  end

  assign out_valid_o  = out_valid_q;
  assign victim_way_o = victim_q;

  a_clock_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && (head.op == OP_STAMP || head.op == OP_TICK))
      |=> (clock_q == $past(clock_q) + 32'd1))
    else $error("Access clock did not advance by one after an access request.");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR || state_q == S_SCAN || state_q == S_RESULT) |-> !q_pop_o)
    else $error("Queue popped while the back end was busy.");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= last_q))
    else $error("Way scan ran past the last way in use.");

  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_RESULT) |-> ($past(state_q) == S_SCAN))
    else $error("Result state entered without a completed scan.");

endmodule

// ===== rtl/cache_way_replacement_policy_unit.sv =====
`timescale 1ns / 1ps
// Top level of the cache way replacement policy unit with its configuration registers.
// After reset the unit clears its stamp RAM one entry per cycle, all NUM_SETS * MAX_WAYS
// entries (512 by default), and stalls its input request channel meanwhile; configuration
// writes are taken at any time. A two-entry queue separates the front end, which takes one
// request per cycle when the queue has room and no clearing pass runs, from the back end.
// In the back end an access request and a random-mode query are served in the idle state,
// and an LRU query passes through the scan and result states, where the single read port
// of the stamp RAM delivers one way's stamp per cycle to the compare unit. A result waits
// in an output register while new requests keep entering the queue.
module cache_way_replacement_policy_unit import cwrp_pkg::*; #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned MAX_WAYS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [SET_IDX_W-1:0]  set_index_i,
  input  logic [HIT_WAY_W-1:0]  hit_way_i,
  input  logic [CLEAN_W-1:0]    clean_mask_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VICTIM_W-1:0]   victim_way_o
);

  localparam int unsigned DEPTH   = NUM_SETS * MAX_WAYS;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned ENTRY_W = OP_W + ADDR_W + MAX_WAYS + WAY_W + VICTIM_W;

  cwrp_cfg_t          cfg_q;
  logic               q_full;
  logic               q_valid;
  logic               q_push;
  logic               q_pop;
  logic               clearing;
  logic [ENTRY_W-1:0] push_entry;
  logic [ENTRY_W-1:0] head_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy_mode <= MODE_LRU;
      cfg_q.ways_in_use <= WAYS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_POLICY: cfg_q.policy_mode <= cfg_data_i[MODE_W-1:0];
        REG_WAYS:   cfg_q.ways_in_use <= cfg_data_i[WAYS_CFG_W-1:0];
      endcase
    end
  end

  cwrp_front #(
    .NUM_SETS (NUM_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .set_index_i  (set_index_i),
    .hit_way_i    (hit_way_i),
    .clean_mask_i (clean_mask_i),
    .q_full_i     (q_full),
    .clearing_i   (clearing),
    .push_o       (q_push),
    .entry_o      (push_entry)
  );

  cwrp_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (q_pop)
  );

  cwrp_back #(
    .NUM_SETS (NUM_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (head_entry),
    .q_pop_o      (q_pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .victim_way_o (victim_way_o)
  );

endmodule

// ===== tb/tb_cache_way_replacement_policy_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the cache way replacement policy unit with a built-in victim predictor.
module tb_cache_way_replacement_policy_unit;
  import cwrp_pkg::*;

  localparam int unsigned NUM_SETS      = 64;
  localparam int unsigned MAX_WAYS      = 8;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 200;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  localparam logic [CMD_W-1:0]  CMD_ACCESS = 1'b0;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [SET_IDX_W-1:0] set;
    logic [HIT_WAY_W-1:0] way;
    logic [CLEAN_W-1:0]   mask;
  } request_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] mode_data;
    logic [CFG_DATA_W-1:0] ways_data;
    request_t              req;
    logic                  typed;
    logic [VICTIM_W-1:0]   typed_way;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 23;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{4'(MODE_LRU),   4'd8,  '{CMD_QUERY,  6'd0,  3'd0, 8'h00}, 1'b1, 3'd0},
    '{4'(MODE_LRU),   4'd8,  '{CMD_QUERY,  6'd63, 3'd7, 8'hFF}, 1'b1, 3'd0},
    '{4'(MODE_LRU),   4'd8,  '{CMD_ACCESS, 6'd5,  3'd0, 8'h00}, 1'b0, 3'd0},
    '{4'(MODE_LRU),   4'd8,  '{CMD_ACCESS, 6'd5,  3'd1, 8'h00}, 1'b0, 3'd0},
    '{4'(MODE_LRU),   4'd8,  '{CMD_ACCESS, 6'd5,  3'd7, 8'hFF}, 1'b0, 3'd0},
    '{4'(MODE_LRU),   4'd8,  '{CMD_QUERY,  6'd5,  3'd0, 8'h00}, 1'b0, 3'd0},
    '{4'(MODE_LRU),   4'd8,  '{CMD_ACCESS, 6'd63, 3'd7, 8'h00}, 1'b0, 3'd0},
    '{4'(MODE_LRU),   4'd8,  '{CMD_QUERY,  6'd63, 3'd0, 8'h80}, 1'b0, 3'd0},
    '{4'(MODE_CLEAN), 4'd8,  '{CMD_QUERY,  6'd5,  3'd0, 8'h00}, 1'b0, 3'd0},
    '{4'(MODE_CLEAN), 4'd8,  '{CMD_QUERY,  6'd5,  3'd0, 8'hFF}, 1'b0, 3'd0},
    '{4'(MODE_CLEAN), 4'd8,  '{CMD_QUERY,  6'd5,  3'd0, 8'h80}, 1'b0, 3'd0},
    '{4'(MODE_CLEAN), 4'd8,  '{CMD_QUERY,  6'd5,  3'd0, 8'h03}, 1'b0, 3'd0},
    '{4'(MODE_CLEAN), 4'd2,  '{CMD_QUERY,  6'd5,  3'd0, 8'hFC}, 1'b0, 3'd0},
    '{4'(MODE_CLEAN), 4'd2,  '{CMD_ACCESS, 6'd5,  3'd3, 8'h00}, 1'b0, 3'd0},
    '{4'(MODE_RAND),  4'd8,  '{CMD_QUERY,  6'd5,  3'd0, 8'h00}, 1'b1, 3'd2},
    '{4'(MODE_RAND),  4'd8,  '{CMD_ACCESS, 6'd5,  3'd2, 8'h00}, 1'b0, 3'd0},
    '{4'(MODE_RAND),  4'd8,  '{CMD_QUERY,  6'd63, 3'd0, 8'hFF}, 1'b0, 3'd0},
    '{4'(MODE_RAND),  4'd1,  '{CMD_QUERY,  6'd0,  3'd0, 8'h00}, 1'b1, 3'd0},
    '{4'(MODE_SPARE), 4'd0,  '{CMD_QUERY,  6'd5,  3'd0, 8'hFF}, 1'b1, 3'd0},
    '{4'(MODE_SPARE), 4'd0,  '{CMD_ACCESS, 6'd5,  3'd4, 8'h00}, 1'b0, 3'd0},
    '{4'(MODE_LRU),   4'd15, '{CMD_QUERY,  6'd5,  3'd0, 8'h00}, 1'b0, 3'd0},
    '{4'(MODE_LRU),   4'd15, '{CMD_QUERY,  6'd63, 3'd0, 8'h55}, 1'b0, 3'd0},
    '{4'(MODE_LRU),   4'd4,  '{CMD_QUERY,  6'd5,  3'd0, 8'h0F}, 1'b0, 3'd0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      command_i;
  logic [SET_IDX_W-1:0]  set_index_i;
  logic [HIT_WAY_W-1:0]  hit_way_i;
  logic [CLEAN_W-1:0]    clean_mask_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [VICTIM_W-1:0]   victim_way_o;

  logic [STAMP_W-1:0]    stamp_model [NUM_SETS][MAX_WAYS];
  logic [STAMP_W-1:0]    clock_model;
  logic [LFSR_W-1:0]     lfsr_model;
  logic [MODE_W-1:0]     mode_model;
  logic [WAYS_CFG_W-1:0] ways_model;
  logic [CFG_DATA_W-1:0] cur_mode_data;
  logic [CFG_DATA_W-1:0] cur_ways_data;

  logic [VICTIM_W-1:0]   victims_due [$];
  logic [SET_IDX_W-1:0]  hot_sets [4];
  int unsigned           errors;
  int unsigned           cycle_count;
  bit                    idle_en;
  bit                    long_hold_req;

  cache_way_replacement_policy_unit #(
    .NUM_SETS(NUM_SETS),
    .MAX_WAYS(MAX_WAYS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .set_index_i (set_index_i),
    .hit_way_i   (hit_way_i),
    .clean_mask_i(clean_mask_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .victim_way_o(victim_way_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic predict_request(input request_t r, output bit makes_victim,
                                 output logic [VICTIM_W-1:0] victim);
    int unsigned          w;
    logic [MAX_WAYS-1:0]  all_ways;
    logic [MAX_WAYS-1:0]  allowed;
    logic [STAMP_W-1:0]   best_stamp;
    logic [31:0]          scaled;
    logic                 fb;
    bit                   have;
    w = ways_model;
    if (w < 1) w = 1;
    if (w > MAX_WAYS) w = MAX_WAYS;
    all_ways = MAX_WAYS'((1 << w) - 1);
    makes_victim = 1'b0;
    victim = '0;
    if (r.cmd != CMD_QUERY) begin
      if (mode_model != MODE_RAND) stamp_model[r.set][r.way] = clock_model;
      clock_model = clock_model + 1;
    end else begin
      makes_victim = 1'b1;
      if (mode_model == MODE_RAND) begin
        fb = lfsr_model[0] ^ lfsr_model[2] ^ lfsr_model[3] ^ lfsr_model[5];
        lfsr_model = {fb, lfsr_model[LFSR_W-1:1]};
        scaled = 32'(lfsr_model) * w;
        victim = scaled[LFSR_W+VICTIM_W-1:LFSR_W];
      end else begin
        if (mode_model == MODE_CLEAN && (r.mask & all_ways) != '0) allowed = r.mask & all_ways;
        else allowed = all_ways;
        have = 1'b0;
        best_stamp = '0;
        for (int unsigned i = 0; i < w; i++) begin
          if (allowed[i] && (!have || stamp_model[r.set][i] < best_stamp)) begin
            victim = VICTIM_W'(i);
            best_stamp = stamp_model[r.set][i];
            have = 1'b1;
          end
        end
      end
    end
  endtask

  function automatic int unsigned draw_gap();
    return idle_en ? $urandom_range(0, 7) : 0;
  endfunction

  function automatic request_t make_request();
    request_t    r;
    int unsigned pick;
    r.cmd = ($urandom_range(0, 9) < 4) ? CMD_QUERY : CMD_ACCESS;
    r.set = ($urandom_range(0, 9) < 7) ? hot_sets[$urandom_range(0, 3)]
                                       : SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
    r.way = HIT_WAY_W'($urandom_range(0, 7));
    pick = $urandom_range(0, 7);
    if (pick == 0) r.mask = '0;
    else if (pick == 1) r.mask = '1;
    else r.mask = CLEAN_W'($urandom);
    return r;
  endfunction

  task automatic send_request(input request_t r, input int unsigned gap, input bit typed,
                              input logic [VICTIM_W-1:0] typed_way);
    bit                  makes_victim;
    logic [VICTIM_W-1:0] victim;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= r.cmd;
    set_index_i  <= r.set;
    hit_way_i    <= r.way;
    clean_mask_i <= r.mask;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(r, makes_victim, victim);
    if (makes_victim) victims_due.push_back(typed ? typed_way : victim);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    wait (victims_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] mode_data,
                              input logic [CFG_DATA_W-1:0] ways_data);
    drain_requests();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_POLICY;
    cfg_data_i  <= mode_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_WAYS;
    cfg_data_i  <= ways_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_model    = mode_data[MODE_W-1:0];
    ways_model    = ways_data;
    cur_mode_data = mode_data;
    cur_ways_data = ways_data;
  endtask

  always @(posedge clk_i) begin : check_victims
    logic [VICTIM_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (victims_due.size() == 0) begin
        $error("victim_way: expected none, actual %0d", victim_way_o);
        errors++;
      end else begin
        want = victims_due.pop_front();
        if (victim_way_o !== want) begin
          $error("victim_way: expected %0d, actual %0d", want, victim_way_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = draw_gap();
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    logic [MODE_W-1:0]     mode_pick;
    logic [WAYS_CFG_W-1:0] ways_pick;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    command_i     = '0;
    set_index_i   = '0;
    hit_way_i     = '0;
    clean_mask_i  = '0;
    out_stall_i   = 1'b0;
    errors        = 0;
    cycle_count   = 0;
    idle_en       = 1'b1;
    long_hold_req = 1'b0;
    clock_model   = '0;
    lfsr_model    = LFSR_SEED;
    mode_model    = MODE_LRU;
    ways_model    = WAYS_RESET;
    cur_mode_data = CFG_DATA_W'(MODE_LRU);
    cur_ways_data = CFG_DATA_W'(WAYS_RESET);
    for (int s = 0; s < NUM_SETS; s++)
      for (int w = 0; w < MAX_WAYS; w++) stamp_model[s][w] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode_data != cur_mode_data || dir_rows[i].ways_data != cur_ways_data)
        write_config(dir_rows[i].mode_data, dir_rows[i].ways_data);
      send_request(dir_rows[i].req, draw_gap(), dir_rows[i].typed, dir_rows[i].typed_way);
    end

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: begin mode_pick = MODE_LRU;   ways_pick = 4'd8;  end
        1: begin mode_pick = MODE_CLEAN; ways_pick = 4'd1;  end
        2: begin mode_pick = MODE_RAND;  ways_pick = 4'd8;  end
        3: begin mode_pick = MODE_SPARE; ways_pick = 4'd0;  end
        4: begin mode_pick = MODE_CLEAN; ways_pick = 4'd15; end
        5: begin mode_pick = MODE_RAND;  ways_pick = 4'd1;  end
        default: begin
          mode_pick = MODE_W'($urandom_range(0, 3));
          ways_pick = WAYS_CFG_W'($urandom_range(1, 8));
        end
      endcase
      write_config({2'($urandom_range(0, 3)), mode_pick}, ways_pick);
      foreach (hot_sets[h]) hot_sets[h] = SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
      idle_en = !(p == 4 || p == 8);
      if (p == 6) long_hold_req = 1'b1;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 7 && n == PHASE_ITEMS / 2) begin
          in_valid_i <= 1'b0;
          wait (victims_due.size() == 0);
          @(posedge clk_i);
        end
        send_request(make_request(), draw_gap(), 1'b0, '0);
      end
    end

    drain_requests();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
